// ===== rtl/fslfa_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fslfa_pkg
// shared constants and types of the fixed slot free list allocator
// ----------------------------------------------------------------------------
package fslfa_pkg;

   // pool geometry
   localparam int SLOTS_PER_BLOCK = 512;
   localparam int NUM_BLOCKS      = 4;
   localparam int POOL_SLOTS      = SLOTS_PER_BLOCK * NUM_BLOCKS;

   // widths
   localparam int SLOT_W = 11;                          // slot index field
   localparam int LINK_W = $clog2(POOL_SLOTS + 1);      // link incl. null code
   localparam int BLK_W  = $clog2(NUM_BLOCKS + 1);      // carved block count
   localparam int OFF_W  = $clog2(SLOTS_PER_BLOCK);     // offset inside a block

   localparam logic [LINK_W-1:0] NULL_CODE = LINK_W'(POOL_SLOTS);

   // request codes
   localparam logic REQ_ALLOC = 1'b0;
   localparam logic REQ_FREE  = 1'b1;

   // response status codes
   typedef enum logic [1:0] {
      STATUS_OK         = 2'd0,
      STATUS_EXHAUSTED  = 2'd1,
      STATUS_NULL_FREE  = 2'd2,
      STATUS_OUT_REGION = 2'd3
   } status_type;

   // link memory write port
   typedef struct packed {
      logic              en;
      logic [SLOT_W-1:0] addr;
      logic [LINK_W-1:0] data;
   } link_wr_type;

   // carve engine status
   typedef struct packed {
      logic busy;
      logic last;
   } carve_status_type;

endpackage

// ===== rtl/fslfa_link_ram.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fslfa_link_ram
// next-link memory, one write port and one registered read port
// ----------------------------------------------------------------------------
module fslfa_link_ram
   import fslfa_pkg::*;
(
   input  logic              clock,
   input  link_wr_type       wr,
   input  logic              rd_en,
   input  logic [SLOT_W-1:0] rd_addr,
   output logic [LINK_W-1:0] rd_data
);

   logic [LINK_W-1:0] mem [POOL_SLOTS];
   logic [LINK_W-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // read port, data held until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/fslfa_carve.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fslfa_carve
// links the slots of a new block in ascending order, one write per cycle
// ----------------------------------------------------------------------------
module fslfa_carve
   import fslfa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   input  logic [SLOT_W-1:0] base,
   output link_wr_type       wr,
   output carve_status_type  status
);

   logic              busy_ff;
   logic [OFF_W-1:0]  idx_ff;
   logic [SLOT_W-1:0] base_ff;
   logic [SLOT_W-1:0] addr;
   logic              last;

   // current entry and end of the chain
   assign addr = base_ff + SLOT_W'(idx_ff);
   assign last = (idx_ff == OFF_W'(SLOTS_PER_BLOCK - 1));

   // sweep control
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
      end else if (start) begin
         busy_ff <= 1'b1;
      end else if (busy_ff && last) begin
         busy_ff <= 1'b0;
      end
   end

   // sweep position, slot zero of the block is granted and never linked
   always_ff @(posedge clock) begin
      if (start) begin
         base_ff <= base;
         idx_ff  <= OFF_W'(1);
      end else if (busy_ff) begin
         idx_ff  <= idx_ff + OFF_W'(1);
      end
   end

   // link write
   always_comb begin
      wr.en   = busy_ff;
      wr.addr = addr;
      wr.data = last ? NULL_CODE : (LINK_W'(addr) + LINK_W'(1));
   end

   assign status.busy = busy_ff;
   assign status.last = last;

endmodule

// ===== rtl/fixed_slot_free_list_allocator_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// fixed_slot_free_list_allocator_core
// free list allocator over a pool of fixed size slots with block carving
// ----------------------------------------------------------------------------
// sequence: free and rejected requests are captured in idle and answered from
// exec, a pop from the list passes through the pop state (link memory read), an
// allocate that carves a block answers from exec and then holds the carve state
// for the link writes before the next request; one transaction at a time, a new
// request is taken only in idle, and a stalled response output holds exec or pop
// reset: synchronous, empties the list (head null) and clears the carve count
// ----------------------------------------------------------------------------
module fixed_slot_free_list_allocator_core
   import fslfa_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  logic              req_type,
   input  logic [SLOT_W-1:0] req_slot_index,
   input  logic              req_is_null,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output logic [SLOT_W-1:0] rsp_granted_slot,
   output logic [1:0]        rsp_status
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP,
      ST_CARVE
   } state_type;

   state_type         state_ff;
   logic [LINK_W-1:0] head_ff;
   logic [BLK_W-1:0]  carved_ff;
   logic              type_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic              null_ff;
   logic              rsp_valid_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   status_type        rsp_status_ff;

   logic              out_free;
   logic              head_valid;
   logic              can_carve;
   logic [LINK_W-1:0] limit;
   logic              free_in_region;
   logic              carve_start;
   link_wr_type       free_wr;
   link_wr_type       carve_wr;
   link_wr_type       ram_wr;
   logic              rd_en;
   logic [LINK_W-1:0] rd_data;
   carve_status_type  carve_st;

   // decode of the captured transaction
   assign out_free       = !rsp_valid_ff || rsp_ready;
   assign head_valid     = (head_ff < NULL_CODE);
   assign can_carve      = (carved_ff < BLK_W'(NUM_BLOCKS));
   assign limit          = LINK_W'(carved_ff) * LINK_W'(SLOTS_PER_BLOCK);
   assign free_in_region = (LINK_W'(slot_ff) < limit);

   // link memory accesses
   assign rd_en       = (state_ff == ST_EXEC) && (type_ff == REQ_ALLOC) && head_valid;
   assign carve_start = (state_ff == ST_EXEC) && out_free && (type_ff == REQ_ALLOC)
                        && !head_valid && can_carve;

   always_comb begin
      free_wr.en   = (state_ff == ST_EXEC) && out_free && (type_ff == REQ_FREE)
                     && !null_ff && free_in_region;
      free_wr.addr = slot_ff;
      free_wr.data = head_ff;
   end

   // carve sweep owns the write port while it runs
   assign ram_wr = carve_st.busy ? carve_wr : free_wr;

   fslfa_link_ram u_link_ram (
      .clock   (clock),
      .wr      (ram_wr),
      .rd_en   (rd_en),
      .rd_addr (head_ff[SLOT_W-1:0]),
      .rd_data (rd_data)
   );

   fslfa_carve u_carve (
      .clock  (clock),
      .reset  (reset),
      .start  (carve_start),
      .base   (limit[SLOT_W-1:0]),
      .wr     (carve_wr),
      .status (carve_st)
   );

   // state machine, list state and response register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         head_ff      <= NULL_CODE;
         carved_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (req_valid) begin
                  type_ff  <= req_type;
                  slot_ff  <= req_slot_index;
                  null_ff  <= req_is_null;
                  state_ff <= ST_EXEC;
               end
            end
            ST_EXEC: begin
               if (type_ff == REQ_ALLOC && head_valid) begin
                  state_ff <= ST_POP;
               end else if (out_free) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_slot_ff  <= '0;
                  state_ff     <= ST_IDLE;
                  if (type_ff == REQ_ALLOC) begin
                     if (can_carve) begin
                        // hand out slot zero of the new block
                        rsp_slot_ff   <= limit[SLOT_W-1:0];
                        rsp_status_ff <= STATUS_OK;
                        head_ff       <= limit + LINK_W'(1);
                        carved_ff     <= carved_ff + BLK_W'(1);
                        state_ff      <= ST_CARVE;
                     end else begin
                        rsp_status_ff <= STATUS_EXHAUSTED;
                     end
                  end else if (null_ff) begin
                     rsp_status_ff <= STATUS_NULL_FREE;
                  end else if (!free_in_region) begin
                     rsp_status_ff <= STATUS_OUT_REGION;
                  end else begin
                     // push onto the head
                     rsp_status_ff <= STATUS_OK;
                     head_ff       <= LINK_W'(slot_ff);
                  end
               end
            end
            ST_POP: begin
               if (out_free) begin
                  rsp_valid_ff  <= 1'b1;
                  rsp_slot_ff   <= head_ff[SLOT_W-1:0];
                  rsp_status_ff <= STATUS_OK;
                  head_ff       <= rd_data;
                  state_ff      <= ST_IDLE;
               end
            end
            ST_CARVE: begin
               if (carve_st.last) begin
                  state_ff <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign req_ready        = (state_ff == ST_IDLE);
   assign rsp_valid        = rsp_valid_ff;
   assign rsp_granted_slot = rsp_slot_ff;
   assign rsp_status       = rsp_status_ff;

   // carve sweep runs only inside the carve state
   a_carve_in_state: assert property (@(posedge clock) disable iff (reset)
      carve_st.busy |-> (state_ff == ST_CARVE))
      else $error("carve sweep active outside carve state");

   // head is a slot index or the null code
   a_head_range: assert property (@(posedge clock) disable iff (reset)
      head_ff <= NULL_CODE)
      else $error("list head out of range");

   // carve count never passes the block count
   a_carved_range: assert property (@(posedge clock) disable iff (reset)
      carved_ff <= BLK_W'(NUM_BLOCKS))
      else $error("carved block count out of range");

   // only a successful allocate grants a nonzero slot
   a_grant_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status != STATUS_OK) |-> (rsp_granted_slot == '0))
      else $error("nonzero slot on rejected transaction");

endmodule
